FILE: hdl/mandelbrot_escape_time_defines.svh
// Assertion macros used by the escape-time sequencer
`ifndef MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MBET_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define MBET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mbet_pkg.sv
// Types and constants of the Mandelbrot escape-time block
`timescale 1ns / 1ps

package mbet_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 28;
    localparam int CNT_WIDTH  = 16;

    localparam logic [CNT_WIDTH-1:0] MAX_ITER_RESET = 16'd20000;

    // orbit register width, operand width of the multipliers, product and square widths
    localparam int ZW  = DATA_WIDTH + 4;
    localparam int MW  = FRAC_BITS + 3;
    localparam int PW  = 2 * MW;
    localparam int SQW = 2 * FRAC_BITS + 4;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] c_real;
        logic signed [DATA_WIDTH-1:0] c_imag;
    } point_t;

    typedef struct packed {
        logic [CNT_WIDTH-1:0] escape_count;
        logic                 escaped;
    } result_t;

    typedef struct packed {
        logic start;
        logic mul;
        logic advance;
        logic load_result;
    } dp_cmd_t;

    typedef struct packed {
        logic escape;
        logic at_limit;
    } dp_status_t;

endpackage

FILE: hdl/mbet_datapath.sv
// Orbit registers, multipliers, escape test and result register
`timescale 1ns / 1ps

module mbet_datapath
    import mbet_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  point_t               point,
    input  logic                 cfg_we,
    input  logic [CNT_WIDTH-1:0] cfg_data,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    output result_t              result
);

    localparam logic signed [ZW-1:0] TWO_Z     = ZW'(2) << FRAC_BITS;
    localparam logic signed [ZW-1:0] NEG_TWO_Z = -TWO_Z;
    localparam logic [SQW:0]         FOUR_SQ   = (SQW + 1)'(4) << (2 * FRAC_BITS);

    logic [CNT_WIDTH-1:0]         max_iter_reg;
    logic signed [DATA_WIDTH-1:0] c_real_reg;
    logic signed [DATA_WIDTH-1:0] c_imag_reg;
    logic signed [ZW-1:0]         z_real_reg;
    logic signed [ZW-1:0]         z_imag_reg;
    logic signed [ZW-1:0]         z_real_next;
    logic signed [ZW-1:0]         z_imag_next;
    logic [CNT_WIDTH-1:0]         count_reg;
    logic signed [PW-1:0]         xx_reg;
    logic signed [PW-1:0]         yy_reg;
    logic signed [PW-1:0]         xy_reg;
    logic signed [PW-1:0]         xx_next;
    logic signed [PW-1:0]         yy_next;
    logic signed [PW-1:0]         xy_next;
    logic                         big_reg;
    logic                         big_next;
    logic signed [MW-1:0]         x_narrow;
    logic signed [MW-1:0]         y_narrow;
    logic signed [PW-1:0]         diff;
    logic signed [PW-1:0]         re_shift;
    logic signed [PW-1:0]         im_shift;
    logic [SQW:0]                 mag_sq;
    result_t                      result_reg;

    // stored orbit stays within +-2.0 unless big, so the low bits carry it
    assign x_narrow = z_real_reg[MW-1:0];
    assign y_narrow = z_imag_reg[MW-1:0];

    assign xx_next  = x_narrow * x_narrow;
    assign yy_next  = y_narrow * y_narrow;
    assign xy_next  = x_narrow * y_narrow;
    assign big_next = (z_real_reg > TWO_Z) || (z_real_reg < NEG_TWO_Z)
                   || (z_imag_reg > TWO_Z) || (z_imag_reg < NEG_TWO_Z);

    assign mag_sq = {1'b0, xx_reg[SQW-1:0]} + {1'b0, yy_reg[SQW-1:0]};

    assign diff        = xx_reg - yy_reg;
    assign re_shift    = diff >>> FRAC_BITS;
    assign im_shift    = xy_reg >>> (FRAC_BITS - 1);
    assign z_real_next = ZW'(re_shift) + ZW'(c_real_reg);
    assign z_imag_next = ZW'(im_shift) + ZW'(c_imag_reg);

    assign status.escape   = big_reg || (mag_sq > FOUR_SQ);
    assign status.at_limit = (count_reg == max_iter_reg);
    assign result          = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_ITER_RESET;
        end
        else if (cfg_we)
        begin
            max_iter_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            c_real_reg <= point.c_real;
            c_imag_reg <= point.c_imag;
            z_real_reg <= '0;
            z_imag_reg <= '0;
            count_reg  <= '0;
        end
        else if (cmd.advance)
        begin
            z_real_reg <= z_real_next;
            z_imag_reg <= z_imag_next;
            count_reg  <= count_reg + 1'b1;
        end

        if (cmd.mul)
        begin
            xx_reg  <= xx_next;
            yy_reg  <= yy_next;
            xy_reg  <= xy_next;
            big_reg <= big_next;
        end

        if (cmd.load_result)
        begin
            result_reg.escaped      <= status.escape;
            result_reg.escape_count <= status.escape ? count_reg : '0;
        end
    end

endmodule

FILE: hdl/mbet_ctrl.sv
// Sequencer for the escape-time iteration and the result handshake
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_defines.svh"

module mbet_ctrl
    import mbet_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       point_valid,
    output logic       point_ready,
    output logic       result_valid,
    input  logic       result_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ADD  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free     = !out_valid_reg || result_ready;
    assign point_ready  = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (point_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (status.escape || status.at_limit)
                begin
                    // hold until the output register frees up
                    if (out_free)
                    begin
                        cmd.load_result = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.load_result || (out_valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `MBET_ASSERT_NOW(a_load_only_when_free, clk, rst_n, cmd.load_result, out_free, "result overwritten while waiting")
    `MBET_ASSERT_NOW(a_advance_only_when_running, clk, rst_n, cmd.advance, !status.escape && !status.at_limit, "orbit advanced past escape or limit")
    `MBET_ASSERT_NEXT(a_accept_starts_iteration, clk, rst_n, point_valid && point_ready, state_reg == S_MUL, "accepted point did not start iterating")
    `MBET_ASSERT_NEXT(a_load_raises_valid, clk, rst_n, cmd.load_result, result_valid && point_ready, "loaded result not presented")

endmodule

FILE: hdl/mandelbrot_escape_time.sv
// A point is taken only in idle, so no new point enters until the last result is loaded;
//          a point stops at the iteration where it escapes, or at max_iterations if bounded.
// Each iteration is a multiply step followed by an add-and-test step through the shared
//          three-multiplier datapath; a result waits for the output register to be free.
// Reset: rst_n clears the sequencer and output valid, and sets max_iterations to 20000.
`timescale 1ns / 1ps

module mandelbrot_escape_time
    import mbet_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 point_valid,
    output logic                 point_ready,
    input  point_t               point,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CNT_WIDTH-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    mbet_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    mbet_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .point    (point),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .result   (result)
    );

endmodule
